// File: rtl/qas_pkg.sv
// ----------------------------------------------------------------------------
// qas_pkg
// Shared constants and types of the quoted argument splitter: character
// codes, quote modes, register map and the result record.
// ----------------------------------------------------------------------------
package qas_pkg;

    // character codes
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_BS     = 8'h08;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_S   = 8'h73;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // quote modes
    localparam logic [1:0] QM_NONE   = 2'd0;
    localparam logic [1:0] QM_SINGLE = 2'd1;
    localparam logic [1:0] QM_DOUBLE = 2'd2;

    // argument counter
    localparam int          CNT_W   = 10;
    localparam logic [9:0]  CNT_MAX = 10'd1023;

    // register map
    localparam int          PADDR_W        = 3;
    localparam int          PDATA_W        = 32;
    localparam logic        REG_MAX_ARGS   = 1'b0;
    localparam logic [9:0]  MAX_ARGS_RESET = 10'd64;

    // result queue
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0]       arg_byte;
        logic             byte_valid;
        logic             arg_end;
        logic [CNT_W-1:0] arg_number;
        logic             arg_kept;
        logic             run_last;
    } result_t;

endpackage

// File: rtl/quoted_argument_splitter.sv
// ----------------------------------------------------------------------------
// quoted_argument_splitter
// Shell style argument splitter: one character per input beat, argument
// bytes and end marks out.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries char_in and string_end. Each beat
// is decoded in the cycle it is accepted and gives zero, one or two result
// beats, which go into a four-entry result queue. The output channel
// (out_valid/out_ready) drains that queue one result beat per cycle
// while out_ready is high; results enter the queue as their beat is accepted.
// Throughput: one input beat per cycle while results drain; a beat that makes
// two results (escape with a kept backslash, trailing backslash with end mark)
// takes two output beats, so the sustained character rate is set by the single
// output port of the result queue.
// in_ready is high while the queue holds at most two results, so a stalled
// receiver holds back input once three or more results wait; nothing is lost.
// max_args is written over the APB port (address 0). The user must write it
// only while the block is idle; the block itself does not enforce this. Reset
// clears the parser state, the argument count and the queue, and sets max_args to 64.
// ----------------------------------------------------------------------------
module quoted_argument_splitter (
    input  logic                        clk,
    input  logic                        rst_n,
    // character input
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [7:0]                  char_in,
    input  logic                        string_end,
    // result output
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [7:0]                  arg_byte,
    output logic                        byte_valid,
    output logic                        arg_end,
    output logic [qas_pkg::CNT_W-1:0]   arg_number,
    output logic                        arg_kept,
    output logic                        run_last,
    // configuration
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [qas_pkg::PADDR_W-1:0] paddr,
    input  logic [qas_pkg::PDATA_W-1:0] pwdata,
    output logic [qas_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import qas_pkg::*;

    // parser state
    logic             in_token_reg, in_token_next;
    logic [1:0]       quote_mode_reg, quote_mode_next;
    logic             escape_reg, escape_next;
    logic             saw_quote_reg, saw_quote_next;
    logic             has_bytes_reg, has_bytes_next;
    logic [CNT_W-1:0] arg_count_reg, arg_count_next;
    logic [CNT_W-1:0] max_args_reg;

    // result queue
    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_CW-1:0] count_reg, count_next;

    logic             in_fire, out_fire, cfg_write;
    logic [CNT_W-1:0] cur_number;
    logic             cur_kept;
    logic [1:0]       nres;
    result_t          res0, res1;
    logic             tok_eff, has_eff, quote_close;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[PADDR_W-1] == REG_MAX_ARGS);

    always_comb
    begin
        prdata = '0;
        if (paddr[PADDR_W-1] == REG_MAX_ARGS)
        begin
            prdata[CNT_W-1:0] = max_args_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_args_reg <= MAX_ARGS_RESET;
        end
        else if (cfg_write)
        begin
            max_args_reg <= pwdata[CNT_W-1:0];
        end
    end

    // handshakes
    assign in_ready  = (count_reg <= FIFO_CW'(FIFO_DEPTH - 2));
    assign in_fire   = in_valid && in_ready;
    assign out_valid = (count_reg != '0);
    assign out_fire  = out_valid && out_ready;

    // number of the argument being built
    assign cur_number = (arg_count_reg != CNT_MAX) ? arg_count_reg + 1'b1 : CNT_MAX;
    assign cur_kept   = (cur_number <= max_args_reg);

    // character decode
    always_comb
    begin
        in_token_next   = in_token_reg;
        quote_mode_next = quote_mode_reg;
        escape_next     = escape_reg;
        saw_quote_next  = saw_quote_reg;
        has_bytes_next  = has_bytes_reg;
        arg_count_next  = arg_count_reg;
        nres            = 2'd0;
        tok_eff         = in_token_reg;
        has_eff         = has_bytes_reg;

        res0            = '0;
        res0.arg_number = cur_number;
        res0.arg_kept   = cur_kept;
        res0.byte_valid = 1'b1;
        res1            = res0;

        quote_close = ((quote_mode_reg == QM_SINGLE) && (char_in == CH_SQUOTE)) ||
                      ((quote_mode_reg == QM_DOUBLE) && (char_in == CH_DQUOTE));

        if (string_end)
        begin
            // end of string: flush a lone backslash, then close the argument
            if (escape_reg)
            begin
                res0.arg_byte = CH_BSLASH;
                nres          = 2'd1;
                tok_eff       = 1'b1;
                has_eff       = 1'b1;
            end
            if (tok_eff && (has_eff || saw_quote_reg))
            begin
                if (nres == 2'd0)
                begin
                    res0.byte_valid = 1'b0;
                    res0.arg_end    = 1'b1;
                end
                else
                begin
                    res1.byte_valid = 1'b0;
                    res1.arg_end    = 1'b1;
                end
                nres           = nres + 2'd1;
                arg_count_next = cur_number;
            end
            in_token_next   = 1'b0;
            quote_mode_next = QM_NONE;
            escape_next     = 1'b0;
            saw_quote_next  = 1'b0;
            has_bytes_next  = 1'b0;
        end
        else if (escape_reg)
        begin
            // escaped character
            escape_next    = 1'b0;
            in_token_next  = 1'b1;
            has_bytes_next = 1'b1;
            nres           = 2'd1;
            res0.arg_byte  = char_in;
            res1.arg_byte  = char_in;
            case (char_in)
                CH_BSLASH: res0.arg_byte = CH_BSLASH;
                CH_LC_R:   res0.arg_byte = CH_CR;
                CH_LC_N:   res0.arg_byte = CH_LF;
                CH_LC_T:   res0.arg_byte = CH_TAB;
                CH_LC_S:   res0.arg_byte = CH_SPACE;
                CH_LC_B:   res0.arg_byte = CH_BS;
                CH_SQUOTE, CH_DQUOTE:
                begin
                    if ((quote_mode_reg != QM_NONE) && !quote_close)
                    begin
                        res0.arg_byte = CH_BSLASH;
                        nres          = 2'd2;
                    end
                end
                CH_SPACE, CH_TAB, CH_LF: res0.arg_byte = char_in;
                default:
                begin
                    res0.arg_byte = CH_BSLASH;
                    nres          = 2'd2;
                end
            endcase
        end
        else if (quote_close)
        begin
            quote_mode_next = QM_NONE;
        end
        else if ((char_in == CH_SPACE) || (char_in == CH_TAB) || (char_in == CH_LF))
        begin
            if (quote_mode_reg != QM_NONE)
            begin
                res0.arg_byte  = char_in;
                nres           = 2'd1;
                in_token_next  = 1'b1;
                has_bytes_next = 1'b1;
            end
            else
            begin
                // unquoted whitespace closes the argument
                if (in_token_reg && (has_bytes_reg || saw_quote_reg))
                begin
                    res0.byte_valid = 1'b0;
                    res0.arg_end    = 1'b1;
                    nres            = 2'd1;
                    arg_count_next  = cur_number;
                end
                in_token_next   = 1'b0;
                escape_next     = 1'b0;
                saw_quote_next  = 1'b0;
                has_bytes_next  = 1'b0;
            end
        end
        else if ((char_in == CH_SQUOTE) || (char_in == CH_DQUOTE))
        begin
            if (quote_mode_reg != QM_NONE)
            begin
                res0.arg_byte  = char_in;
                nres           = 2'd1;
                in_token_next  = 1'b1;
                has_bytes_next = 1'b1;
            end
            else
            begin
                in_token_next   = 1'b1;
                saw_quote_next  = 1'b1;
                quote_mode_next = (char_in == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
            end
        end
        else if (char_in == CH_BSLASH)
        begin
            in_token_next = 1'b1;
            escape_next   = 1'b1;
        end
        else
        begin
            res0.arg_byte  = char_in;
            nres           = 2'd1;
            in_token_next  = 1'b1;
            has_bytes_next = 1'b1;
        end

        // mark the last result of this beat
        if (nres == 2'd2)
        begin
            res1.run_last = 1'b1;
        end
        else
        begin
            res0.run_last = 1'b1;
        end
    end

    // parser state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_token_reg   <= 1'b0;
            quote_mode_reg <= QM_NONE;
            escape_reg     <= 1'b0;
            saw_quote_reg  <= 1'b0;
            has_bytes_reg  <= 1'b0;
            arg_count_reg  <= '0;
        end
        else if (in_fire)
        begin
            in_token_reg   <= in_token_next;
            quote_mode_reg <= quote_mode_next;
            escape_reg     <= escape_next;
            saw_quote_reg  <= saw_quote_next;
            has_bytes_reg  <= has_bytes_next;
            arg_count_reg  <= arg_count_next;
        end
    end

    // queue occupancy
    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
        begin
            count_next = count_next + FIFO_CW'(nres);
        end
        if (out_fire)
        begin
            count_next = count_next - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (in_fire)
            begin
                wr_ptr_reg <= wr_ptr_reg + FIFO_AW'(nres);
            end
            if (out_fire)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (in_fire && (nres != 2'd0))
        begin
            fifo_mem[wr_ptr_reg] <= res0;
        end
        if (in_fire && (nres == 2'd2))
        begin
            fifo_mem[wr_ptr_reg + 1'b1] <= res1;
        end
    end

    // output beat
    assign arg_byte   = fifo_mem[rd_ptr_reg].arg_byte;
    assign byte_valid = fifo_mem[rd_ptr_reg].byte_valid;
    assign arg_end    = fifo_mem[rd_ptr_reg].arg_end;
    assign arg_number = fifo_mem[rd_ptr_reg].arg_number;
    assign arg_kept   = fifo_mem[rd_ptr_reg].arg_kept;
    assign run_last   = fifo_mem[rd_ptr_reg].run_last;

endmodule

// File: bench/quoted_argument_splitter_tb.sv
// ----------------------------------------------------------------------------
// quoted_argument_splitter_tb
// Self-checking bench for the quoted argument splitter. A short table of
// directed characters comes first, then weighted random character streams
// in several phases, each with a max_args setting written first and one of
// four idling patterns on the two channels. Every accepted character goes
// through a local predictor of the splitter. Each result beat is compared
// field by field with the oldest predicted beat.
// ----------------------------------------------------------------------------
module quoted_argument_splitter_tb;

    import qas_pkg::*;

    localparam int PHASES       = 8;
    localparam int PHASE_ITEMS  = 200;
    localparam int LONG_HOLD    = 80;
    localparam int DRAIN_CYCLES = 8;

    // how a directed row is checked
    typedef enum logic [1:0] {
        CHK_PREDICT,
        CHK_NONE,
        CHK_ONE
    } row_check_t;

    typedef struct {
        logic [7:0] c;
        logic       e;
        row_check_t check;
        logic [7:0] exp_byte;
        logic       exp_valid;
        logic       exp_end;
        logic [9:0] exp_num;
    } stim_row_t;

    // directed table, starting right after reset with max_args at 64
    stim_row_t directed_rows [25] = '{
        '{8'h41,     1'b0, CHK_ONE,     8'h41,    1'b1, 1'b0, 10'd1},
        '{CH_NUL,    1'b0, CHK_ONE,     CH_NUL,   1'b1, 1'b0, 10'd1},
        '{8'hFF,     1'b0, CHK_ONE,     8'hFF,    1'b1, 1'b0, 10'd1},
        '{CH_BSLASH, 1'b0, CHK_NONE,    CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_SPACE,  1'b0, CHK_ONE,     CH_SPACE, 1'b1, 1'b0, 10'd1},
        '{CH_TAB,    1'b0, CHK_ONE,     CH_NUL,   1'b0, 1'b1, 10'd1},
        '{CH_LF,     1'b0, CHK_NONE,    CH_NUL,   1'b0, 1'b0, 10'd0},
        '{8'hFF,     1'b1, CHK_NONE,    CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_DQUOTE, 1'b0, CHK_NONE,    CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_DQUOTE, 1'b0, CHK_NONE,    CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_SPACE,  1'b0, CHK_ONE,     CH_NUL,   1'b0, 1'b1, 10'd2},
        '{CH_SQUOTE, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_BSLASH, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_DQUOTE, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_BSLASH, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_SQUOTE, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_SPACE,  1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_SQUOTE, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_BSLASH, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{8'h71,     1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_BSLASH, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_LC_N,   1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_DQUOTE, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_BSLASH, 1'b0, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0},
        '{CH_NUL,    1'b1, CHK_PREDICT, CH_NUL,   1'b0, 1'b0, 10'd0}
    };

    // dut signals
    logic               clk        = 1'b0;
    logic               rst_n      = 1'b0;
    logic               in_valid   = 1'b0;
    logic               in_ready;
    logic [7:0]         char_in    = 8'h00;
    logic               string_end = 1'b0;
    logic               out_valid;
    logic               out_ready  = 1'b0;
    logic [7:0]         arg_byte;
    logic               byte_valid;
    logic               arg_end;
    logic [CNT_W-1:0]   arg_number;
    logic               arg_kept;
    logic               run_last;
    logic               psel       = 1'b0;
    logic               penable    = 1'b0;
    logic               pwrite     = 1'b0;
    logic [PADDR_W-1:0] paddr      = '0;
    logic [PDATA_W-1:0] pwdata     = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // splitter model state
    logic [9:0]         max_args_model  = MAX_ARGS_RESET;
    logic               in_arg          = 1'b0;
    logic [1:0]         quote_state     = QM_NONE;
    logic               escape_waiting  = 1'b0;
    logic               arg_had_quote   = 1'b0;
    logic               arg_had_bytes   = 1'b0;
    logic [9:0]         arg_count_model = '0;

    // predicted beats of the current character and of all pending ones
    result_t            char_results [$];
    result_t            arg_results_due [$];

    // sender side controls
    row_check_t         row_check     = CHK_PREDICT;
    result_t            typed_result  = '0;
    int                 in_idle_pct   = 0;
    int                 out_stall_pct = 0;
    logic               hold_toggle   = 1'b0;
    logic               hold_seen     = 1'b0;
    int                 hold_left     = 0;
    int                 mismatch_count = 0;

    quoted_argument_splitter uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .char_in    (char_in),
        .string_end (string_end),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .arg_byte   (arg_byte),
        .byte_valid (byte_valid),
        .arg_end    (arg_end),
        .arg_number (arg_number),
        .arg_kept   (arg_kept),
        .run_last   (run_last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always #5 clk = ~clk;

    // add one predicted beat, at most two per character
    function automatic void push_result(logic [7:0] b, logic valid, logic fin);
        result_t    r;
        logic [9:0] num;
        num = (arg_count_model < CNT_MAX) ? arg_count_model + 10'd1 : CNT_MAX;
        if (char_results.size() < 2)
        begin
            r.arg_byte   = b;
            r.byte_valid = valid;
            r.arg_end    = fin;
            r.arg_number = num;
            r.arg_kept   = (num <= max_args_model);
            r.run_last   = 1'b0;
            char_results.push_back(r);
        end
    endfunction

    function automatic void emit_char(logic [7:0] b);
        push_result(b, 1'b1, 1'b0);
        arg_had_bytes = 1'b1;
        in_arg        = 1'b1;
    endfunction

    // end mark only for an argument with bytes or a quote
    function automatic void close_arg();
        if (in_arg && (arg_had_bytes || arg_had_quote))
        begin
            push_result(CH_NUL, 1'b0, 1'b1);
            if (arg_count_model < CNT_MAX)
                arg_count_model = arg_count_model + 10'd1;
        end
        in_arg         = 1'b0;
        quote_state    = QM_NONE;
        escape_waiting = 1'b0;
        arg_had_quote  = 1'b0;
        arg_had_bytes  = 1'b0;
    endfunction

    function automatic bit closes_quote(logic [7:0] c);
        return (quote_state == QM_SINGLE && c == CH_SQUOTE) ||
               (quote_state == QM_DOUBLE && c == CH_DQUOTE);
    endfunction

    function automatic bit is_blank(logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF;
    endfunction

    // predict the beats of one accepted character
    function automatic void split_char(logic [7:0] c, logic e);
        char_results.delete();
        if (e)
        begin
            // trailing backslash gives a lone backslash, then the close
            if (escape_waiting)
            begin
                escape_waiting = 1'b0;
                emit_char(CH_BSLASH);
            end
            close_arg();
        end
        else if (escape_waiting)
        begin
            escape_waiting = 1'b0;
            case (c)
                CH_BSLASH: emit_char(CH_BSLASH);
                CH_LC_R:   emit_char(CH_CR);
                CH_LC_N:   emit_char(CH_LF);
                CH_LC_T:   emit_char(CH_TAB);
                CH_LC_S:   emit_char(CH_SPACE);
                CH_LC_B:   emit_char(CH_BS);
                CH_SQUOTE, CH_DQUOTE:
                begin
                    if (quote_state != QM_NONE && !closes_quote(c))
                        emit_char(CH_BSLASH);
                    emit_char(c);
                end
                CH_SPACE, CH_TAB, CH_LF: emit_char(c);
                default:
                begin
                    emit_char(CH_BSLASH);
                    emit_char(c);
                end
            endcase
        end
        else if (quote_state != QM_NONE && closes_quote(c))
            quote_state = QM_NONE;
        else if (is_blank(c))
        begin
            if (quote_state != QM_NONE)
                emit_char(c);
            else
                close_arg();
        end
        else if (c == CH_SQUOTE || c == CH_DQUOTE)
        begin
            if (quote_state != QM_NONE)
                emit_char(c);
            else
            begin
                in_arg        = 1'b1;
                arg_had_quote = 1'b1;
                quote_state   = (c == CH_SQUOTE) ? QM_SINGLE : QM_DOUBLE;
            end
        end
        else if (c == CH_BSLASH)
        begin
            in_arg         = 1'b1;
            escape_waiting = 1'b1;
        end
        else
            emit_char(c);
        if (char_results.size() > 0)
            char_results[char_results.size()-1].run_last = 1'b1;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(2))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            default: return CH_LF;
        endcase
    endfunction

    // weighted random character: string ends, quotes, escapes, blanks, letters, noise
    function automatic void pick_item(output logic [7:0] c, output logic e);
        int r;
        r = $urandom_range(99);
        e = 1'b0;
        c = 8'($urandom);
        if (r < 5)
            e = 1'b1;
        else if (r < 15)
            c = CH_BSLASH;
        else if (r < 22)
            c = CH_SQUOTE;
        else if (r < 29)
            c = CH_DQUOTE;
        else if (r < 41)
            c = pick_blank();
        else if (r < 56)
        begin
            case ($urandom_range(4))
                0:       c = CH_LC_R;
                1:       c = CH_LC_N;
                2:       c = CH_LC_T;
                3:       c = CH_LC_S;
                default: c = CH_LC_B;
            endcase
        end
        else if (r < 90)
            c = 8'h61 + 8'($urandom_range(25));
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // offer one input beat and wait for its handshake
    task automatic send_item(logic [7:0] c, logic e, row_check_t chk, result_t res);
        @(negedge clk);
        while ($urandom_range(99) < in_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid     = 1'b1;
        char_in      = c;
        string_end   = e;
        row_check    = chk;
        typed_result = res;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // stop offering, wait for every pending beat, then let the block settle
    task automatic finish_phase();
        @(negedge clk);
        in_valid = 1'b0;
        while (arg_results_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // apb write of max_args: setup cycle, then access cycle
    task automatic write_max_args(logic [9:0] value);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {REG_MAX_ARGS, 2'b00};
        pwdata  = {22'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        max_args_model = value;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // receiver: random stalls, plus a long hold when the sender asks
    always @(negedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen = hold_toggle;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
            out_ready = ($urandom_range(99) >= out_stall_pct);
    end

    // predict accepted input beats, check accepted result beats
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                split_char(char_in, string_end);
                case (row_check)
                    CHK_NONE: char_results.delete();
                    CHK_ONE:  char_results = '{typed_result};
                    default:  ;
                endcase
                foreach (char_results[k])
                    arg_results_due.push_back(char_results[k]);
            end
            if (out_valid && out_ready)
            begin
                got = {arg_byte, byte_valid, arg_end, arg_number, arg_kept, run_last};
                if (arg_results_due.size() == 0)
                    report_mismatch($sformatf("result beat %h with nothing pending", got));
                else
                begin
                    want = arg_results_due.pop_front();
                    if (got.arg_byte !== want.arg_byte)
                        report_mismatch($sformatf("arg_byte %h, want %h",
                                                  got.arg_byte, want.arg_byte));
                    if (got.byte_valid !== want.byte_valid)
                        report_mismatch($sformatf("byte_valid %b, want %b",
                                                  got.byte_valid, want.byte_valid));
                    if (got.arg_end !== want.arg_end)
                        report_mismatch($sformatf("arg_end %b, want %b",
                                                  got.arg_end, want.arg_end));
                    if (got.arg_number !== want.arg_number)
                        report_mismatch($sformatf("arg_number %0d, want %0d",
                                                  got.arg_number, want.arg_number));
                    if (got.arg_kept !== want.arg_kept)
                        report_mismatch($sformatf("arg_kept %b, want %b",
                                                  got.arg_kept, want.arg_kept));
                    if (got.run_last !== want.run_last)
                        report_mismatch($sformatf("run_last %b, want %b",
                                                  got.run_last, want.run_last));
                end
            end
        end
    end

    // main sequence
    initial
    begin
        logic [7:0] c;
        logic       e;
        logic [9:0] setting;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table at the reset setting, no idling
        foreach (directed_rows[i])
            send_item(directed_rows[i].c, directed_rows[i].e, directed_rows[i].check,
                      {directed_rows[i].exp_byte, directed_rows[i].exp_valid,
                       directed_rows[i].exp_end, directed_rows[i].exp_num, 1'b1, 1'b1});
        finish_phase();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0:       setting = 10'd0;
                1:       setting = 10'd1023;
                2:       setting = (arg_count_model < 10'd1000) ?
                                   arg_count_model + 10'd10 : 10'd1000;
                3:       setting = 10'($urandom_range(1023));
                4:       setting = 10'd1023;
                5:       setting = 10'd1022;
                6:       setting = 10'($urandom_range(1023));
                default: setting = 10'd0;
            endcase
            write_max_args(setting);
            case (p % 4)
                0:       begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1:       begin in_idle_pct = 51; out_stall_pct = 0;  end
                2:       begin in_idle_pct = 0;  out_stall_pct = 51; end
                default: begin in_idle_pct = 20; out_stall_pct = 20; end
            endcase

            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                // long receiver hold while the sender keeps offering
                if (p == 0 && n == PHASE_ITEMS / 2)
                    hold_toggle = ~hold_toggle;
                pick_item(c, e);
                send_item(c, e, CHK_PREDICT, '0);
            end
            finish_phase();
        end

        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial
    begin
        #3000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
